// ===== rtl/vmee_pkg.sv =====
// Shared types, constants and codes for the voter model event engine.
`default_nettype none

package vmee_pkg;

   localparam int MAX_NODES  = 32;
   localparam int NODE_BITS  = 5;
   localparam int TIME_BITS  = 48;
   localparam int COUNT_BITS = 6;
   localparam int PAIR_BITS  = 9;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_FIRE  = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 6'd30;

   typedef struct packed {
      logic [1:0]           func;
      logic [NODE_BITS-1:0] node_index;
      logic                 opinion_bit;
      logic [TIME_BITS-1:0] time_value;
      logic [NODE_BITS-1:0] neighbour;
   } req_word_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [NODE_BITS-1:0]  next_node;
      logic [TIME_BITS-1:0]  next_time;
      logic [COUNT_BITS-1:0] ones_count;
      logic [PAIR_BITS-1:0]  discordant_pairs;
      logic                  consensus;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_RD_U,
      ST_RD_NB,
      ST_UPDATE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       latch;
      logic       status_we;
      logic [1:0] status_code;
      logic       load_write;
      logic       start_init;
      logic       read_nb;
      logic       capt_u;
      logic       fire_update;
      logic       scan_issue;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       idx_bad;
      logic       fire_bad;
      logic       fire_reject;
      logic       scan_last;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/voter_model_event_engine.sv =====
// Top level of the voter model event engine: controller, datapath and ports.
// A start or fire scans all n nodes before its result strobe, with n the node count in use
// (2 to 32); loads, rejected or out-of-range words and the unused func skip the scan.
// One word at a time: the next word is taken the cycle after the strobe, so the pace of fires
// is set by the scan through the single read port of the node memory.
// Synchronous reset clears counts and selection and sets node_count to 30; the node memory
// is undefined until loaded and gets no clearing pass. Results cannot be stalled.
`default_nettype none

module voter_model_event_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire vmee_pkg::req_word_type          req_data,
   output      logic                            rsp_valid,
   output      vmee_pkg::rsp_word_type          rsp_data,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [vmee_pkg::COUNT_BITS-1:0] csr_data
);

   vmee_pkg::dp_cmd_type  cmd;
   vmee_pkg::dp_stat_type stat;
   logic                  csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   vmee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   vmee_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/vmee_datapath.sv =====
// Datapath of the voter model event engine: node memory, counters, earliest-time scan.
`default_nettype none

module vmee_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire vmee_pkg::dp_cmd_type                cmd,
   output      vmee_pkg::dp_stat_type               stat,
   input  wire vmee_pkg::req_word_type              req_data,
   input  wire logic                                csr_write,
   input  wire logic [vmee_pkg::COUNT_BITS-1:0]     csr_data,
   output      vmee_pkg::rsp_word_type              rsp_data
);

   typedef struct packed {
      logic                           opinion;
      logic [vmee_pkg::TIME_BITS-1:0] fire_time;
   } node_entry_type;

   node_entry_type node_mem_ff [vmee_pkg::MAX_NODES];
   node_entry_type rd_data_ff;
   node_entry_type mem_wdata;
   logic [vmee_pkg::NODE_BITS-1:0] mem_waddr;
   logic [vmee_pkg::NODE_BITS-1:0] rd_addr;
   logic                           mem_we;

   logic [vmee_pkg::COUNT_BITS-1:0] node_count_ff, node_count_in;
   vmee_pkg::req_word_type          req_ff, req_in;
   logic [1:0]                      status_ff, status_in;
   logic [vmee_pkg::COUNT_BITS-1:0] ones_ff, ones_in;
   logic [vmee_pkg::PAIR_BITS-1:0]  pairs_ff, pairs_in;
   logic [vmee_pkg::NODE_BITS-1:0]  current_node_ff, current_node_in;
   logic [vmee_pkg::TIME_BITS-1:0]  current_time_ff, current_time_in;
   logic [vmee_pkg::NODE_BITS-1:0]  scan_k_ff, scan_k_in;
   logic                            cmp_valid_ff, cmp_valid_in;
   logic [vmee_pkg::NODE_BITS-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                            ou_ff, ou_in;
   logic [vmee_pkg::TIME_BITS-1:0]  tu_ff, tu_in;

   logic [vmee_pkg::COUNT_BITS-1:0]   n_use;
   logic [vmee_pkg::COUNT_BITS-1:0]   zeros;
   logic [2*vmee_pkg::COUNT_BITS-1:0] start_prod;
   logic [vmee_pkg::PAIR_BITS-1:0]    start_pairs;
   logic [vmee_pkg::TIME_BITS:0]      sum_wide;
   logic [vmee_pkg::TIME_BITS-1:0]    sat_time;
   logic                              on_bit;
   logic signed [11:0]                n_s, ones_s, pairs_s, delta_s, sum_s;
   logic [vmee_pkg::PAIR_BITS-1:0]    fire_pairs;
   logic [vmee_pkg::COUNT_BITS-1:0]   fire_ones;
   logic [vmee_pkg::COUNT_BITS-1:0]   load_ones;

   // clamp the node count into the usable range
   always_comb begin
      if (node_count_ff < 6'd2) begin
         n_use = 6'd2;
      end else if (node_count_ff > vmee_pkg::COUNT_BITS'(vmee_pkg::MAX_NODES)) begin
         n_use = vmee_pkg::COUNT_BITS'(vmee_pkg::MAX_NODES);
      end else begin
         n_use = node_count_ff;
      end
   end

   always_comb begin
      stat.func        = req_ff.func;
      stat.idx_bad     = {1'b0, req_ff.node_index} >= n_use;
      stat.fire_bad    = ({1'b0, current_node_ff} >= n_use) ||
                         ({1'b0, req_ff.neighbour} >= n_use);
      stat.fire_reject = req_ff.neighbour == current_node_ff;
      stat.scan_last   = {1'b0, scan_k_ff} == (n_use - 6'd1);
   end

   // start: pairs = ones * zeros
   always_comb begin
      zeros      = n_use - ones_ff;
      start_prod = ones_ff * zeros;
      if (ones_ff > n_use) begin
         start_pairs = '0;
      end else if (start_prod > 12'd511) begin
         start_pairs = '1;
      end else begin
         start_pairs = start_prod[vmee_pkg::PAIR_BITS-1:0];
      end
   end

   // fire: saturating time advance and incremental counts
   always_comb begin
      sum_wide = {1'b0, tu_ff} + {1'b0, req_ff.time_value};
      sat_time = sum_wide[vmee_pkg::TIME_BITS] ? '1 : sum_wide[vmee_pkg::TIME_BITS-1:0];
      on_bit   = rd_data_ff.opinion;
      n_s      = $signed({6'd0, n_use});
      ones_s   = $signed({6'd0, ones_ff});
      pairs_s  = $signed({3'd0, pairs_ff});
      if (!ou_ff && on_bit) begin
         delta_s = n_s - (ones_s <<< 1) - 12'sd1;
      end else if (ou_ff && !on_bit) begin
         delta_s = (ones_s <<< 1) - n_s - 12'sd1;
      end else begin
         delta_s = 12'sd0;
      end
      sum_s = pairs_s + delta_s;
      if (sum_s < 12'sd0) begin
         fire_pairs = '0;
      end else if (sum_s > 12'sd511) begin
         fire_pairs = '1;
      end else begin
         fire_pairs = sum_s[vmee_pkg::PAIR_BITS-1:0];
      end
      if (on_bit && !ou_ff && (ones_ff != '1)) begin
         fire_ones = ones_ff + 6'd1;
      end else if (!on_bit && ou_ff && (ones_ff != '0)) begin
         fire_ones = ones_ff - 6'd1;
      end else begin
         fire_ones = ones_ff;
      end
      if (req_ff.opinion_bit && (ones_ff != '1)) begin
         load_ones = ones_ff + 6'd1;
      end else begin
         load_ones = ones_ff;
      end
   end

   always_comb begin
      mem_we    = cmd.load_write || cmd.fire_update;
      mem_waddr = cmd.load_write ? req_ff.node_index : current_node_ff;
      if (cmd.load_write) begin
         mem_wdata.opinion   = req_ff.opinion_bit;
         mem_wdata.fire_time = req_ff.time_value;
      end else begin
         mem_wdata.opinion   = on_bit;
         mem_wdata.fire_time = sat_time;
      end
      if (cmd.scan_issue) begin
         rd_addr = scan_k_ff;
      end else if (cmd.read_nb) begin
         rd_addr = req_ff.neighbour;
      end else begin
         rd_addr = current_node_ff;
      end
   end

   always_comb begin
      node_count_in   = csr_write ? csr_data : node_count_ff;
      req_in          = cmd.latch ? req_data : req_ff;
      status_in       = cmd.status_we ? cmd.status_code : status_ff;
      ones_in         = ones_ff;
      pairs_in        = pairs_ff;
      current_node_in = current_node_ff;
      current_time_in = current_time_ff;
      scan_k_in       = scan_k_ff;
      ou_in           = ou_ff;
      tu_in           = tu_ff;
      cmp_valid_in    = cmd.scan_issue;
      cmp_idx_in      = scan_k_ff;
      if (cmd.load_write) begin
         ones_in = load_ones;
      end
      if (cmd.start_init) begin
         pairs_in        = start_pairs;
         current_node_in = '0;
         current_time_in = '1;
         scan_k_in       = '0;
      end
      if (cmd.capt_u) begin
         ou_in = rd_data_ff.opinion;
         tu_in = rd_data_ff.fire_time;
      end
      if (cmd.fire_update) begin
         pairs_in        = fire_pairs;
         ones_in         = fire_ones;
         current_time_in = sat_time;
         scan_k_in       = '0;
      end
      if (cmd.scan_issue) begin
         scan_k_in = scan_k_ff + 5'd1;
      end
      // take a strictly earlier node only
      if (cmp_valid_ff && (rd_data_ff.fire_time < current_time_ff)) begin
         current_node_in = cmp_idx_ff;
         current_time_in = rd_data_ff.fire_time;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= node_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff   <= vmee_pkg::NODE_COUNT_RESET;
         ones_ff         <= '0;
         pairs_ff        <= '0;
         current_node_ff <= '0;
         current_time_ff <= '0;
         scan_k_ff       <= '0;
         cmp_valid_ff    <= 1'b0;
      end else begin
         node_count_ff   <= node_count_in;
         ones_ff         <= ones_in;
         pairs_ff        <= pairs_in;
         current_node_ff <= current_node_in;
         current_time_ff <= current_time_in;
         scan_k_ff       <= scan_k_in;
         cmp_valid_ff    <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      status_ff  <= status_in;
      cmp_idx_ff <= cmp_idx_in;
      ou_ff      <= ou_in;
      tu_ff      <= tu_in;
   end

   always_comb begin
      rsp_data.status           = status_ff;
      rsp_data.next_node        = current_node_ff;
      rsp_data.next_time        = current_time_ff;
      rsp_data.ones_count       = ones_ff;
      rsp_data.discordant_pairs = pairs_ff;
      rsp_data.consensus        = (ones_ff == '0) || (ones_ff == n_use);
   end

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_write |-> !stat.idx_bad)
      else $error("load written with index beyond node count");

   a_fire_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_update |-> (!stat.fire_bad && !stat.fire_reject))
      else $error("fire update on bad or rejected draw");

endmodule

`default_nettype wire

// ===== rtl/vmee_ctrl.sv =====
// Controller state machine of the voter model event engine.
`default_nettype none

module vmee_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   output      logic                  rsp_valid,
   output      vmee_pkg::dp_cmd_type  cmd,
   input  wire vmee_pkg::dp_stat_type stat
);

   vmee_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vmee_pkg::ST_IDLE: begin
            if (start) begin
               state_in = vmee_pkg::ST_DECODE;
            end
         end
         vmee_pkg::ST_DECODE: begin
            unique case (stat.func)
               vmee_pkg::FUNC_LOAD: begin
                  state_in = stat.idx_bad ? vmee_pkg::ST_DONE : vmee_pkg::ST_LOAD;
               end
               vmee_pkg::FUNC_START: begin
                  state_in = vmee_pkg::ST_SCAN;
               end
               vmee_pkg::FUNC_FIRE: begin
                  if (stat.fire_bad || stat.fire_reject) begin
                     state_in = vmee_pkg::ST_DONE;
                  end else begin
                     state_in = vmee_pkg::ST_RD_U;
                  end
               end
               vmee_pkg::FUNC_NOP: begin
                  state_in = vmee_pkg::ST_DONE;
               end
            endcase
         end
         vmee_pkg::ST_LOAD:   state_in = vmee_pkg::ST_DONE;
         vmee_pkg::ST_RD_U:   state_in = vmee_pkg::ST_RD_NB;
         vmee_pkg::ST_RD_NB:  state_in = vmee_pkg::ST_UPDATE;
         vmee_pkg::ST_UPDATE: state_in = vmee_pkg::ST_SCAN;
         vmee_pkg::ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = vmee_pkg::ST_DRAIN;
            end
         end
         vmee_pkg::ST_DRAIN:  state_in = vmee_pkg::ST_DONE;
         vmee_pkg::ST_DONE:   state_in = vmee_pkg::ST_IDLE;
         default:             state_in = vmee_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         vmee_pkg::ST_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         vmee_pkg::ST_DECODE: begin
            cmd.status_we   = 1'b1;
            cmd.status_code = vmee_pkg::STATUS_DONE;
            unique case (stat.func)
               vmee_pkg::FUNC_LOAD: begin
                  if (stat.idx_bad) begin
                     cmd.status_code = vmee_pkg::STATUS_RANGE;
                  end
               end
               vmee_pkg::FUNC_START: begin
                  cmd.start_init = 1'b1;
               end
               vmee_pkg::FUNC_FIRE: begin
                  if (stat.fire_bad) begin
                     cmd.status_code = vmee_pkg::STATUS_RANGE;
                  end else if (stat.fire_reject) begin
                     cmd.status_code = vmee_pkg::STATUS_REJECT;
                  end
               end
               vmee_pkg::FUNC_NOP: begin
                  cmd.status_code = vmee_pkg::STATUS_DONE;
               end
            endcase
         end
         vmee_pkg::ST_LOAD:   cmd.load_write = 1'b1;
         vmee_pkg::ST_RD_U:   cmd.read_nb = 1'b0;
         vmee_pkg::ST_RD_NB: begin
            cmd.read_nb = 1'b1;
            cmd.capt_u  = 1'b1;
         end
         vmee_pkg::ST_UPDATE: cmd.fire_update = 1'b1;
         vmee_pkg::ST_SCAN:   cmd.scan_issue = 1'b1;
         vmee_pkg::ST_DRAIN:  cmd.scan_issue = 1'b0;
         vmee_pkg::ST_DONE:   rsp_valid = 1'b1;
         default:             busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vmee_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word did not make the engine busy");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the voter model event engine: directed and random words.
`timescale 1ns / 100ps

module tb_top;

   typedef logic [vmee_pkg::TIME_BITS-1:0]  time_type;
   typedef logic [vmee_pkg::NODE_BITS-1:0]  node_type;
   typedef logic [vmee_pkg::COUNT_BITS-1:0] count_type;
   typedef logic [vmee_pkg::PAIR_BITS-1:0]  pair_type;

   localparam int       WATCHDOG_LIMIT = 1000;
   localparam int       DRAIN_CYCLES   = 50;
   localparam time_type TIME_MAX       = '1;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   vmee_pkg::req_word_type req_data  = '0;
   logic                   rsp_valid;
   vmee_pkg::rsp_word_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   count_type              csr_data  = '0;

   voter_model_event_engine uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   count_type node_count_set = vmee_pkg::NODE_COUNT_RESET;
   logic      opinion_mem [vmee_pkg::MAX_NODES];
   time_type  time_mem [vmee_pkg::MAX_NODES];
   int        ones_held  = 0;
   int        pairs_held = 0;
   node_type  sel_node   = '0;
   time_type  sel_time   = '0;

   vmee_pkg::rsp_word_type expected_rsp [$];
   int                     error_count     = 0;
   int                     sender_idle_pct = 8;
   int                     quiet_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int nodes_now();
      if (node_count_set < 2) return 2;
      if (node_count_set > vmee_pkg::MAX_NODES) return vmee_pkg::MAX_NODES;
      return int'(node_count_set);
   endfunction

   function automatic int clip(input int v, input int lo, input int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic void pick_earliest(input int n, input int first);
      int k;
      sel_node = node_type'(first);
      sel_time = time_mem[first];
      for (k = 0; k < n; k++) begin
         if (time_mem[k] < sel_time) begin
            sel_node = node_type'(k);
            sel_time = time_mem[k];
         end
      end
   endfunction

   function automatic vmee_pkg::req_word_type make_word(input logic [1:0] func, input int idx,
         input int op, input time_type tv, input int nb);
      vmee_pkg::req_word_type w;
      w.func        = func;
      w.node_index  = node_type'(idx);
      w.opinion_bit = op[0];
      w.time_value  = tv;
      w.neighbour   = node_type'(nb);
      return w;
   endfunction

   function automatic time_type pick_time();
      case ($urandom_range(19))
         0:       return '0;
         1:       return TIME_MAX;
         2:       return time_type'({$urandom, $urandom});
         3, 4:    return time_type'($urandom_range(0, 3)) << 16;
         default: return time_type'($urandom_range(0, 1 << 22));
      endcase
   endfunction

   function automatic int opinion_holder(input logic value, input int skip);
      int k;
      int found [$];
      for (k = 0; k < nodes_now(); k++) begin
         if (opinion_mem[k] === value && k != skip) found.push_back(k);
      end
      return (found.size() == 0) ? skip : found[$urandom_range(0, found.size() - 1)];
   endfunction

   task automatic predict_engine(input vmee_pkg::req_word_type w);
      vmee_pkg::rsp_word_type      r;
      int                          n;
      int                          ou;
      int                          on;
      logic [vmee_pkg::TIME_BITS:0] total;
      n = nodes_now();
      r = '0;
      r.status = vmee_pkg::STATUS_DONE;
      case (w.func)
         vmee_pkg::FUNC_LOAD: begin
            if (w.node_index >= n) begin
               r.status = vmee_pkg::STATUS_RANGE;
            end else begin
               opinion_mem[w.node_index] = w.opinion_bit;
               time_mem[w.node_index]    = w.time_value;
               ones_held = clip(ones_held + int'(w.opinion_bit), 0, 63);
            end
         end
         vmee_pkg::FUNC_START: begin
            pairs_held = (ones_held > n) ? 0 : clip(ones_held * (n - ones_held), 0, 511);
            pick_earliest(n, 0);
         end
         vmee_pkg::FUNC_FIRE: begin
            if (sel_node >= n || w.neighbour >= n) begin
               r.status = vmee_pkg::STATUS_RANGE;
            end else if (w.neighbour == sel_node) begin
               r.status = vmee_pkg::STATUS_REJECT;
            end else begin
               total = {1'b0, time_mem[sel_node]} + w.time_value;
               time_mem[sel_node] = total[vmee_pkg::TIME_BITS] ? TIME_MAX :
                                    total[vmee_pkg::TIME_BITS-1:0];
               ou = int'(opinion_mem[sel_node]);
               on = int'(opinion_mem[w.neighbour]);
               if (ou == 0) pairs_held += (on - ou) * (n - 2 * ones_held - 1);
               else pairs_held += (ou - on) * (2 * ones_held - n - 1);
               pairs_held = clip(pairs_held, 0, 511);
               ones_held  = clip(ones_held + on - ou, 0, 63);
               opinion_mem[sel_node] = on[0];
               pick_earliest(n, sel_node);
            end
         end
         vmee_pkg::FUNC_NOP: ;
      endcase
      r.next_node        = sel_node;
      r.next_time        = sel_time;
      r.ones_count       = count_type'(ones_held);
      r.discordant_pairs = pair_type'(pairs_held);
      r.consensus        = (ones_held == 0 || ones_held == n);
      expected_rsp.push_back(r);
   endtask

   task automatic send_word(input vmee_pkg::req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_engine(w);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_node_count(input count_type value);
      wait_drained();
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      node_count_set = value;
   endtask

   task automatic test_load_and_range();
      write_node_count(6'd0);
      send_word(make_word(vmee_pkg::FUNC_NOP, $urandom, 1, TIME_MAX, 31));
      send_word(make_word(vmee_pkg::FUNC_LOAD, 2, 1, 48'h1, 0));
      send_word(make_word(vmee_pkg::FUNC_LOAD, 31, 0, TIME_MAX, 31));
      send_word(make_word(vmee_pkg::FUNC_LOAD, 0, 0, TIME_MAX, 0));
      send_word(make_word(vmee_pkg::FUNC_LOAD, 1, 1, '0, 0));
      send_word(make_word(vmee_pkg::FUNC_START, 0, 0, '0, 0));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, 48'd5, 1));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, 48'd5, 30));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 31, 1, TIME_MAX, 0));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 31, 1, TIME_MAX, 0));
   endtask

   task automatic test_tie_selection();
      write_node_count(6'd4);
      send_word(make_word(vmee_pkg::FUNC_LOAD, 0, 1, 48'd5 << 16, 0));
      send_word(make_word(vmee_pkg::FUNC_LOAD, 1, 0, 48'd10 << 16, 0));
      send_word(make_word(vmee_pkg::FUNC_LOAD, 2, 1, 48'd10 << 16, 0));
      send_word(make_word(vmee_pkg::FUNC_LOAD, 3, 0, 48'd20 << 16, 0));
      send_word(make_word(vmee_pkg::FUNC_START, 0, 0, '0, 0));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, 48'd5 << 16, 1));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, 48'd10 << 16, 2));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, 48'd10 << 16, 3));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, 48'd10 << 16, 0));
   endtask

   task automatic test_stale_selection();
      int k;
      write_node_count(6'd63);
      for (k = 0; k < vmee_pkg::MAX_NODES; k++) begin
         if (k >= 4 || !opinion_mem[k]) begin
            send_word(make_word(vmee_pkg::FUNC_LOAD, k, $urandom,
                                (k == 31) ? '0 : time_type'($urandom_range(1, 1 << 20)), 0));
         end
      end
      send_word(make_word(vmee_pkg::FUNC_START, 0, 0, '0, 0));
      write_node_count(6'd1);
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, 48'd1, 0));
      send_word(make_word(vmee_pkg::FUNC_START, 0, 0, '0, 0));
      send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, pick_time(), $urandom_range(0, 1)));
   endtask

   task automatic test_random_runs(input int word_goal);
      int sent;
      int n;
      int idx;
      int nb;
      sent = 0;
      while (sent < word_goal) begin
         case ($urandom_range(9))
            0, 1, 2: write_node_count(count_type'($urandom_range(2, 4)));
            3:       write_node_count(count_type'(vmee_pkg::MAX_NODES));
            4:       write_node_count(count_type'($urandom_range(0, 1)));
            5:       write_node_count(count_type'($urandom_range(vmee_pkg::MAX_NODES + 1, 63)));
            default: write_node_count(count_type'($urandom_range(2, vmee_pkg::MAX_NODES)));
         endcase
         n = nodes_now();
         repeat ($urandom_range(0, n)) begin
            idx = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1);
            if (idx >= n || !opinion_mem[idx]) begin
               send_word(make_word(vmee_pkg::FUNC_LOAD, idx, $urandom, pick_time(), $urandom));
               if (idx < n) sent++;
            end
         end
         send_word(make_word(vmee_pkg::FUNC_START, $urandom, $urandom, pick_time(), $urandom));
         sent++;
         repeat ($urandom_range(4, 40)) begin
            case ($urandom_range(19))
               0: wait_drained();
               1: send_word(make_word(vmee_pkg::FUNC_NOP, $urandom, $urandom, pick_time(),
                                      $urandom));
               2: send_word(make_word(vmee_pkg::FUNC_START, $urandom, $urandom, pick_time(),
                                      $urandom));
               default: begin
                  case ($urandom_range(9))
                     0:       nb = sel_node;
                     1:       nb = $urandom_range(0, 31);
                     default: nb = $urandom_range(0, n - 1);
                  endcase
                  send_word(make_word(vmee_pkg::FUNC_FIRE, $urandom, $urandom, pick_time(), nb));
                  sent++;
               end
            endcase
         end
      end
   endtask

   task automatic test_counter_limits();
      int k;
      write_node_count(count_type'(vmee_pkg::MAX_NODES));
      k = 0;
      while (ones_held < 63) begin
         send_word(make_word(vmee_pkg::FUNC_LOAD, k % 16, 1,
                             time_type'($urandom_range(0, 1 << 20)), 0));
         k++;
      end
      for (k = 16; k < vmee_pkg::MAX_NODES; k++) begin
         send_word(make_word(vmee_pkg::FUNC_LOAD, k, 0,
                             time_type'($urandom_range(0, 1 << 20)), 0));
      end
      send_word(make_word(vmee_pkg::FUNC_START, 0, 0, '0, 0));
      // drive the pair count up to its ceiling, then back down to zero
      repeat (25) begin
         send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, time_type'($urandom_range(1, 1 << 20)),
                             opinion_holder(1'b0, sel_node)));
      end
      repeat (25) begin
         send_word(make_word(vmee_pkg::FUNC_FIRE, 0, 0, time_type'($urandom_range(1, 1 << 20)),
                             opinion_holder(1'b1, sel_node)));
      end
   endtask

   task automatic check_field(input string name, input time_type want, input time_type got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      vmee_pkg::rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", time_type'(want.status), time_type'(rsp_data.status));
            check_field("next_node", time_type'(want.next_node),
                        time_type'(rsp_data.next_node));
            check_field("next_time", want.next_time, rsp_data.next_time);
            check_field("ones_count", time_type'(want.ones_count),
                        time_type'(rsp_data.ones_count));
            check_field("discordant_pairs", time_type'(want.discordant_pairs),
                        time_type'(rsp_data.discordant_pairs));
            check_field("consensus", time_type'(want.consensus),
                        time_type'(rsp_data.consensus));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_load_and_range();
      test_tie_selection();
      test_stale_selection();
      sender_idle_pct = 8;
      test_random_runs(160);
      sender_idle_pct = 78;
      test_random_runs(160);
      sender_idle_pct = 0;
      test_random_runs(160);
      test_counter_limits();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
